// ===== hw/rtl/dhmc_pkg.sv =====
package dhmc_pkg;

  localparam int DATA_WIDTH_DEF  = 32;
  localparam int COEFF_WIDTH_DEF = 16;
  localparam int DATA_FRAC       = 16;
  localparam int COEFF_FRAC      = 12;
  localparam int NUM_REGS        = 8;
  localparam int REG_IDX_W       = $clog2(NUM_REGS);

  localparam logic [REG_IDX_W-1:0] REG_PZ_LO  = REG_IDX_W'(0);
  localparam logic [REG_IDX_W-1:0] REG_PZ_HI  = REG_IDX_W'(1);
  localparam logic [REG_IDX_W-1:0] REG_PR_LO  = REG_IDX_W'(2);
  localparam logic [REG_IDX_W-1:0] REG_PR_HI  = REG_IDX_W'(3);
  localparam logic [REG_IDX_W-1:0] REG_WINDOW = REG_IDX_W'(4);
  localparam logic [REG_IDX_W-1:0] REG_T0_IMASS = REG_IDX_W'(5);
  localparam logic [REG_IDX_W-1:0] REG_ROT_SCALE = REG_IDX_W'(6);
  localparam logic [REG_IDX_W-1:0] REG_CENTER = REG_IDX_W'(7);

  localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;

  // Signed field of w bits at slot; bits past 63 read as zero.
  function automatic logic signed [63:0] field_s(input logic [63:0] r, input int slot,
                                                 input int w);
    logic [127:0] ext;
    logic signed [63:0] res;
    ext = {64'b0, r} >> (slot * w);
    for (int i = 0; i < 64; i++) begin
      res[i] = (i < w) ? ext[i] : ext[w-1];
    end
    return res;
  endfunction

  // Unsigned field of w bits at slot.
  function automatic logic signed [63:0] field_u(input logic [63:0] r, input int slot,
                                                 input int w);
    logic [127:0] ext;
    logic signed [63:0] res;
    ext = {64'b0, r} >> (slot * w);
    for (int i = 0; i < 64; i++) begin
      res[i] = (i < w) ? ext[i] : 1'b0;
    end
    return res;
  endfunction

  function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [63:0] s;
    s = a + b;
    if (a[63] == b[63] && s[63] != a[63]) begin
      s = a[63] ? S64_MIN : S64_MAX;
    end
    return s;
  endfunction

endpackage

// ===== hw/rtl/dhmc_qmul.sv =====
// Two-stage fixed-point multiply: 32x32 partial products, then combine,
// drop FRAC bits toward zero and saturate.
module dhmc_qmul #(
  parameter int FRAC = dhmc_pkg::DATA_FRAC
) (
  input  logic               clk,
  input  logic               en,
  input  logic signed [63:0] a,
  input  logic signed [63:0] b,
  output logic signed [63:0] p
);

  logic [63:0] ua, ub;
  logic        neg_r;
  logic [63:0] pp00_r, pp01_r, pp10_r, pp11_r;
  logic [127:0] full, shf;
  logic [63:0] mag;
  logic signed [63:0] p_nxt, p_r;

  always_comb begin
    ua = a[63] ? (64'd0 - a) : a;
    ub = b[63] ? (64'd0 - b) : b;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg_r  <= a[63] ^ b[63];
      pp00_r <= {32'b0, ua[31:0]} * {32'b0, ub[31:0]};
      pp01_r <= {32'b0, ua[31:0]} * {32'b0, ub[63:32]};
      pp10_r <= {32'b0, ua[63:32]} * {32'b0, ub[31:0]};
      pp11_r <= {32'b0, ua[63:32]} * {32'b0, ub[63:32]};
    end
  end

  always_comb begin
    full = {64'b0, pp00_r} + ({64'b0, pp01_r} << 32) + ({64'b0, pp10_r} << 32)
         + {pp11_r, 64'b0};
    shf  = full >> FRAC;
    mag  = (|shf[127:63]) ? 64'h7FFF_FFFF_FFFF_FFFF : {1'b0, shf[62:0]};
    p_nxt = neg_r ? -$signed(mag) : $signed(mag);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= p_nxt;
    end
  end

  assign p = p_r;

endmodule

// ===== hw/rtl/dhmc_dly.sv =====
// Enabled shift line, N stages.
module dhmc_dly #(
  parameter int W = 64,
  parameter int N = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] sr_r [N];

  always_ff @(posedge clk) begin
    if (en) begin
      sr_r[0] <= d;
      for (int i = 1; i < N; i++) begin
        sr_r[i] <= sr_r[i-1];
      end
    end
  end

  assign q = sr_r[N-1];

endmodule

// ===== hw/rtl/detector_hit_momentum_calibration.sv =====
// Hit calibration and momentum pipeline.
// Input channel: one hit (time, x, y) per beat on in_valid / in_stall.
// Output channel: one result per hit on out_valid / out_stall, in order:
//   in_window flag, momentum z/x/y and kinetic energy; all zero when the
//   hit time is outside the configured window.
// Configuration: cfg_we writes cfg_data into register cfg_index; write only
//   while no hit is in flight.
// Throughput: one hit per cycle, sustained while no output beat is held.
// Depth: set by the chain of registered 64-bit multipliers (t^2..t^5,
//   u^3, u^5 t) followed by the serial saturating sums.
// Stall: when the output beat is held, the whole pipeline freezes and
//   in_stall is raised; nothing is dropped or repeated. A bubble at the
//   output lets the pipe advance again.
// Reset (rst_n low, synchronous): configuration registers go to zero and
//   all in-flight beats are discarded.
module detector_hit_momentum_calibration #(
  parameter int DATA_WIDTH  = dhmc_pkg::DATA_WIDTH_DEF,
  parameter int COEFF_WIDTH = dhmc_pkg::COEFF_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [DATA_WIDTH-1:0]  in_hit_time,
  input  logic signed [DATA_WIDTH-1:0]  in_hit_x,
  input  logic signed [DATA_WIDTH-1:0]  in_hit_y,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_in_window,
  output logic signed [DATA_WIDTH-1:0]  out_momentum_z,
  output logic signed [DATA_WIDTH-1:0]  out_momentum_x,
  output logic signed [DATA_WIDTH-1:0]  out_momentum_y,
  output logic [DATA_WIDTH-1:0]         out_kinetic_energy,
  input  logic                          cfg_we,
  input  logic [dhmc_pkg::REG_IDX_W-1:0] cfg_index,
  input  logic [63:0]                   cfg_data
);

  localparam int PIPE_DEPTH = 31;
  localparam int CF = dhmc_pkg::COEFF_FRAC;
  localparam int DF = dhmc_pkg::DATA_FRAC;
  localparam logic signed [63:0] SMAX = (64'sd1 <<< (DATA_WIDTH - 1)) - 64'sd1;
  localparam logic signed [63:0] SMIN = -SMAX - 64'sd1;
  localparam logic signed [63:0] KMAX = (64'sd1 <<< DATA_WIDTH) - 64'sd1;

  logic [63:0] cfg_r [dhmc_pkg::NUM_REGS];
  logic [PIPE_DEPTH-1:0] vld_r;
  logic en;

  // config fields
  logic signed [63:0] c_co [7];
  logic signed [63:0] d_co [6];
  logic signed [63:0] lo_bound, up_bound, t0c, inv_m, cs, sn, sx, sy, x0c, y0c, p0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < dhmc_pkg::NUM_REGS; i++) begin
        cfg_r[i] <= 64'd0;
      end
    end else if (cfg_we) begin
      cfg_r[cfg_index] <= cfg_data;
    end
  end

  always_comb begin
    for (int k = 0; k < 7; k++) begin
      if (k < 4) begin
        c_co[k] = dhmc_pkg::field_s(cfg_r[dhmc_pkg::REG_PZ_LO], k, COEFF_WIDTH);
      end else begin
        c_co[k] = dhmc_pkg::field_s(cfg_r[dhmc_pkg::REG_PZ_HI], k - 4, COEFF_WIDTH);
      end
    end
    for (int k = 0; k < 6; k++) begin
      if (k < 4) begin
        d_co[k] = dhmc_pkg::field_s(cfg_r[dhmc_pkg::REG_PR_LO], k, COEFF_WIDTH);
      end else begin
        d_co[k] = dhmc_pkg::field_s(cfg_r[dhmc_pkg::REG_PR_HI], k - 4, COEFF_WIDTH);
      end
    end
    lo_bound = dhmc_pkg::field_s(cfg_r[dhmc_pkg::REG_WINDOW], 0, DATA_WIDTH);
    up_bound = dhmc_pkg::field_s(cfg_r[dhmc_pkg::REG_WINDOW], 1, DATA_WIDTH);
    t0c      = dhmc_pkg::field_s(cfg_r[dhmc_pkg::REG_T0_IMASS], 0, DATA_WIDTH);
    inv_m    = dhmc_pkg::field_u(cfg_r[dhmc_pkg::REG_T0_IMASS], 1, DATA_WIDTH);
    cs       = dhmc_pkg::field_s(cfg_r[dhmc_pkg::REG_ROT_SCALE], 0, COEFF_WIDTH);
    sn       = dhmc_pkg::field_s(cfg_r[dhmc_pkg::REG_ROT_SCALE], 1, COEFF_WIDTH);
    sx       = dhmc_pkg::field_s(cfg_r[dhmc_pkg::REG_ROT_SCALE], 2, COEFF_WIDTH);
    sy       = dhmc_pkg::field_s(cfg_r[dhmc_pkg::REG_ROT_SCALE], 3, COEFF_WIDTH);
    x0c      = dhmc_pkg::field_s(cfg_r[dhmc_pkg::REG_CENTER], 0, DATA_WIDTH);
    y0c      = dhmc_pkg::field_s(cfg_r[dhmc_pkg::REG_CENTER], 1, DATA_WIDTH);
    // c0 times one is an exact shift
    p0       = c_co[0] <<< (DF - CF);
  end

  // global advance: frozen only while a finished beat is held
  assign en       = ~vld_r[PIPE_DEPTH-1] | ~out_stall;
  assign in_stall = ~en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[PIPE_DEPTH-2:0], in_valid};
    end
  end

  // T0: input
  logic signed [63:0] t_in, x_in, y_in, t_r, x_r, y_r;
  logic win_in, win0_r, win29;

  always_comb begin
    t_in = {{(64-DATA_WIDTH){in_hit_time[DATA_WIDTH-1]}}, in_hit_time};
    x_in = {{(64-DATA_WIDTH){in_hit_x[DATA_WIDTH-1]}}, in_hit_x};
    y_in = {{(64-DATA_WIDTH){in_hit_y[DATA_WIDTH-1]}}, in_hit_y};
    win_in = (lo_bound <= t_in) && (t_in <= up_bound);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t_r    <= t_in;
      x_r    <= x_in;
      y_r    <= y_in;
      win0_r <= win_in;
    end
  end

  dhmc_dly #(.W(1), .N(29)) u_dly_win (.clk, .en, .d(win0_r), .q(win29));

  // time chain
  logic signed [63:0] ct1_r, ct3, ct5, ct6, ct7, ct10, ct12, t2, t3, t4, t5;

  always_ff @(posedge clk) begin
    if (en) begin
      ct1_r <= dhmc_pkg::sat_add(t_r, -t0c);
    end
  end

  dhmc_dly #(.W(64), .N(2)) u_dly_ct3  (.clk, .en, .d(ct1_r), .q(ct3));
  dhmc_dly #(.W(64), .N(2)) u_dly_ct5  (.clk, .en, .d(ct3),   .q(ct5));
  dhmc_dly #(.W(64), .N(1)) u_dly_ct6  (.clk, .en, .d(ct5),   .q(ct6));
  dhmc_dly #(.W(64), .N(1)) u_dly_ct7  (.clk, .en, .d(ct6),   .q(ct7));
  dhmc_dly #(.W(64), .N(4)) u_dly_ct10 (.clk, .en, .d(ct6),   .q(ct10));
  dhmc_dly #(.W(64), .N(2)) u_dly_ct12 (.clk, .en, .d(ct10),  .q(ct12));

  dhmc_qmul #(.FRAC(DF)) u_t2 (.clk, .en, .a(ct1_r), .b(ct1_r), .p(t2));
  dhmc_qmul #(.FRAC(DF)) u_t3 (.clk, .en, .a(t2),    .b(ct3),   .p(t3));
  dhmc_qmul #(.FRAC(DF)) u_t4 (.clk, .en, .a(t3),    .b(ct5),   .p(t4));
  dhmc_qmul #(.FRAC(DF)) u_t5 (.clk, .en, .a(t4),    .b(ct7),   .p(t5));

  // rotation, offset, scale
  logic signed [63:0] csx, sny, snx, csy, axa_r, aya_r, ax_r, ay_r;
  logic signed [63:0] cu [2];

  dhmc_qmul #(.FRAC(CF)) u_csx (.clk, .en, .a(cs), .b(x_r), .p(csx));
  dhmc_qmul #(.FRAC(CF)) u_sny (.clk, .en, .a(sn), .b(y_r), .p(sny));
  dhmc_qmul #(.FRAC(CF)) u_snx (.clk, .en, .a(sn), .b(x_r), .p(snx));
  dhmc_qmul #(.FRAC(CF)) u_csy (.clk, .en, .a(cs), .b(y_r), .p(csy));

  always_ff @(posedge clk) begin
    if (en) begin
      axa_r <= dhmc_pkg::sat_add(csx, -sny);
      aya_r <= dhmc_pkg::sat_add(snx, csy);
      ax_r  <= dhmc_pkg::sat_add(axa_r, -x0c);
      ay_r  <= dhmc_pkg::sat_add(aya_r, -y0c);
    end
  end

  dhmc_qmul #(.FRAC(CF)) u_cx (.clk, .en, .a(sx), .b(ax_r), .p(cu[0]));
  dhmc_qmul #(.FRAC(CF)) u_cy (.clk, .en, .a(sy), .b(ay_r), .p(cu[1]));

  // transverse terms that depend on t only, shared by both lanes
  logic signed [63:0] a4, a5, a4d, a5d;

  dhmc_qmul #(.FRAC(CF)) u_a4 (.clk, .en, .a(d_co[4]), .b(t3), .p(a4));
  dhmc_qmul #(.FRAC(CF)) u_a5 (.clk, .en, .a(d_co[5]), .b(t5), .p(a5));
  dhmc_dly #(.W(64), .N(12)) u_dly_a4 (.clk, .en, .d(a4), .q(a4d));
  dhmc_dly #(.W(64), .N(9))  u_dly_a5 (.clk, .en, .d(a5), .q(a5d));

  logic signed [63:0] u2_l [2];
  logic signed [63:0] ps22 [2];

  for (genvar gi = 0; gi < 2; gi++) begin : g_lane
    logic signed [63:0] u2, ut, u8, u3, u2_10, u5, u3t, u5t;
    logic signed [63:0] a0, a1, a2, a3, a0d, a1d, a2d, a3d;
    logic signed [63:0] s17_r, s18_r, s19_r, s20_r, s21_r, s22_r;

    dhmc_qmul #(.FRAC(DF)) u_u2  (.clk, .en, .a(cu[gi]), .b(cu[gi]), .p(u2));
    dhmc_qmul #(.FRAC(DF)) u_ut  (.clk, .en, .a(cu[gi]), .b(ct6),    .p(ut));
    dhmc_dly #(.W(64), .N(2)) u_dly_u8 (.clk, .en, .d(cu[gi]), .q(u8));
    dhmc_qmul #(.FRAC(DF)) u_u3  (.clk, .en, .a(u2), .b(u8),    .p(u3));
    dhmc_dly #(.W(64), .N(2)) u_dly_u2 (.clk, .en, .d(u2), .q(u2_10));
    dhmc_qmul #(.FRAC(DF)) u_u5  (.clk, .en, .a(u3), .b(u2_10), .p(u5));
    dhmc_qmul #(.FRAC(DF)) u_u3t (.clk, .en, .a(u3), .b(ct10),  .p(u3t));
    dhmc_qmul #(.FRAC(DF)) u_u5t (.clk, .en, .a(u5), .b(ct12),  .p(u5t));

    dhmc_qmul #(.FRAC(CF)) u_a0 (.clk, .en, .a(d_co[0]), .b(cu[gi]), .p(a0));
    dhmc_qmul #(.FRAC(CF)) u_a1 (.clk, .en, .a(d_co[1]), .b(ut),     .p(a1));
    dhmc_qmul #(.FRAC(CF)) u_a2 (.clk, .en, .a(d_co[2]), .b(u3t),    .p(a2));
    dhmc_qmul #(.FRAC(CF)) u_a3 (.clk, .en, .a(d_co[3]), .b(u5t),    .p(a3));
    dhmc_dly #(.W(64), .N(8)) u_dly_a0 (.clk, .en, .d(a0), .q(a0d));
    dhmc_dly #(.W(64), .N(6)) u_dly_a1 (.clk, .en, .d(a1), .q(a1d));
    dhmc_dly #(.W(64), .N(3)) u_dly_a2 (.clk, .en, .d(a2), .q(a2d));
    dhmc_dly #(.W(64), .N(2)) u_dly_a3 (.clk, .en, .d(a3), .q(a3d));

    // saturating sum kept in term order, one add per stage, then a final register stage that only holds the sum
    always_ff @(posedge clk) begin
      if (en) begin
        s17_r <= dhmc_pkg::sat_add(a0d, a1d);
        s18_r <= dhmc_pkg::sat_add(s17_r, a2d);
        s19_r <= dhmc_pkg::sat_add(s18_r, a3d);
        s20_r <= dhmc_pkg::sat_add(s19_r, a4d);
        s21_r <= dhmc_pkg::sat_add(s20_r, a5d);
        s22_r <= s21_r;
      end
    end

    assign u2_l[gi] = u2;
    assign ps22[gi] = s22_r;
  end

  // longitudinal
  logic signed [63:0] r2_r, r2r2, p1, p2, p3, p4, p5, p6, p1d, p2d, p3d, p4d, p5d, p6d;
  logic signed [63:0] z17_r, z18_r, z19_r, z20_r, z21_r, z22_r;

  always_ff @(posedge clk) begin
    if (en) begin
      r2_r <= dhmc_pkg::sat_add(u2_l[0], u2_l[1]);
    end
  end

  dhmc_qmul #(.FRAC(DF)) u_r2r2 (.clk, .en, .a(r2_r), .b(r2_r), .p(r2r2));
  dhmc_qmul #(.FRAC(CF)) u_p1 (.clk, .en, .a(c_co[1]), .b(ct1_r), .p(p1));
  dhmc_qmul #(.FRAC(CF)) u_p2 (.clk, .en, .a(c_co[2]), .b(t2),    .p(p2));
  dhmc_qmul #(.FRAC(CF)) u_p3 (.clk, .en, .a(c_co[3]), .b(t3),    .p(p3));
  dhmc_qmul #(.FRAC(CF)) u_p4 (.clk, .en, .a(c_co[4]), .b(t4),    .p(p4));
  dhmc_qmul #(.FRAC(CF)) u_p5 (.clk, .en, .a(c_co[5]), .b(r2_r),  .p(p5));
  dhmc_qmul #(.FRAC(CF)) u_p6 (.clk, .en, .a(c_co[6]), .b(r2r2),  .p(p6));
  dhmc_dly #(.W(64), .N(13)) u_dly_p1 (.clk, .en, .d(p1), .q(p1d));
  dhmc_dly #(.W(64), .N(12)) u_dly_p2 (.clk, .en, .d(p2), .q(p2d));
  dhmc_dly #(.W(64), .N(11)) u_dly_p3 (.clk, .en, .d(p3), .q(p3d));
  dhmc_dly #(.W(64), .N(10)) u_dly_p4 (.clk, .en, .d(p4), .q(p4d));
  dhmc_dly #(.W(64), .N(9))  u_dly_p5 (.clk, .en, .d(p5), .q(p5d));
  dhmc_dly #(.W(64), .N(8))  u_dly_p6 (.clk, .en, .d(p6), .q(p6d));

  always_ff @(posedge clk) begin
    if (en) begin
      z17_r <= dhmc_pkg::sat_add(p0, p1d);
      z18_r <= dhmc_pkg::sat_add(z17_r, p2d);
      z19_r <= dhmc_pkg::sat_add(z18_r, p3d);
      z20_r <= dhmc_pkg::sat_add(z19_r, p4d);
      z21_r <= dhmc_pkg::sat_add(z20_r, p5d);
      z22_r <= dhmc_pkg::sat_add(z21_r, p6d);
    end
  end

  // momenta clamp and energy
  logic signed [63:0] mz_r, mx_r, my_r, qz, qx, qy, qy26, sq1_r, sum_r, half, ke;
  logic signed [63:0] mz29, mx29, my29;

  function automatic logic signed [63:0] clamp_d(input logic signed [63:0] v);
    return (v > SMAX) ? SMAX : ((v < SMIN) ? SMIN : v);
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      mz_r <= clamp_d(z22_r);
      mx_r <= clamp_d(ps22[0]);
      my_r <= clamp_d(ps22[1]);
    end
  end

  dhmc_qmul #(.FRAC(DF)) u_qz (.clk, .en, .a(mz_r), .b(mz_r), .p(qz));
  dhmc_qmul #(.FRAC(DF)) u_qx (.clk, .en, .a(mx_r), .b(mx_r), .p(qx));
  dhmc_qmul #(.FRAC(DF)) u_qy (.clk, .en, .a(my_r), .b(my_r), .p(qy));
  dhmc_dly #(.W(64), .N(1)) u_dly_qy (.clk, .en, .d(qy), .q(qy26));

  always_ff @(posedge clk) begin
    if (en) begin
      sq1_r <= dhmc_pkg::sat_add(qz, qx);
      sum_r <= dhmc_pkg::sat_add(sq1_r, qy26);
    end
  end

  // halve, rounding toward zero
  assign half = (sum_r + {63'b0, sum_r[63]}) >>> 1;

  dhmc_qmul #(.FRAC(DF)) u_ke (.clk, .en, .a(half), .b(inv_m), .p(ke));
  dhmc_dly #(.W(64), .N(6)) u_dly_mz (.clk, .en, .d(mz_r), .q(mz29));
  dhmc_dly #(.W(64), .N(6)) u_dly_mx (.clk, .en, .d(mx_r), .q(mx29));
  dhmc_dly #(.W(64), .N(6)) u_dly_my (.clk, .en, .d(my_r), .q(my29));

  // output register
  logic                  win_o_r;
  logic [DATA_WIDTH-1:0] mz_o_r, mx_o_r, my_o_r, ke_o_r;
  logic [DATA_WIDTH-1:0] ke_sat;

  always_comb begin
    if (ke > KMAX) begin
      ke_sat = KMAX[DATA_WIDTH-1:0];
    end else if (ke < 64'sd0) begin
      ke_sat = '0;
    end else begin
      ke_sat = ke[DATA_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      win_o_r <= win29;
      mz_o_r  <= win29 ? mz29[DATA_WIDTH-1:0] : '0;
      mx_o_r  <= win29 ? mx29[DATA_WIDTH-1:0] : '0;
      my_o_r  <= win29 ? my29[DATA_WIDTH-1:0] : '0;
      ke_o_r  <= win29 ? ke_sat : '0;
    end
  end

  assign out_valid          = vld_r[PIPE_DEPTH-1];
  assign out_in_window      = win_o_r;
  assign out_momentum_z     = mz_o_r;
  assign out_momentum_x     = mx_o_r;
  assign out_momentum_y     = my_o_r;
  assign out_kinetic_energy = ke_o_r;

endmodule

// ===== hw/rtl/dhmc_checker.sv =====
module dhmc_checker #(
  parameter int DATA_WIDTH = dhmc_pkg::DATA_WIDTH_DEF
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_stall,
  input logic                  out_valid,
  input logic                  out_stall,
  input logic                  out_in_window,
  input logic [DATA_WIDTH-1:0] out_momentum_z,
  input logic [DATA_WIDTH-1:0] out_momentum_x,
  input logic [DATA_WIDTH-1:0] out_momentum_y,
  input logic [DATA_WIDTH-1:0] out_kinetic_energy
);

  // held output beat keeps its in_window flag, momentum z and kinetic energy
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_momentum_z)
      && $stable(out_kinetic_energy) && $stable(out_in_window))
    else $error("held output beat changed");

  // a hit outside the window gives all-zero fields
  a_out_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_in_window |-> out_momentum_z == '0 && out_momentum_x == '0
      && out_momentum_y == '0 && out_kinetic_energy == '0)
    else $error("out-of-window beat carries data");

  // input back-pressure only while an output beat is held
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output back-pressure");

  // reset flushes the pipe
  a_rst_flush: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind detector_hit_momentum_calibration dhmc_checker #(.DATA_WIDTH(DATA_WIDTH)) u_dhmc_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_stall           (in_stall),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_in_window      (out_in_window),
  .out_momentum_z     (out_momentum_z),
  .out_momentum_x     (out_momentum_x),
  .out_momentum_y     (out_momentum_y),
  .out_kinetic_energy (out_kinetic_energy)
);

// ===== tb/sv/tb_detector_hit_momentum_calibration.sv =====
`timescale 1ns / 100ps

module tb_detector_hit_momentum_calibration;

  localparam int DW = 32;
  localparam int CW = 16;
  localparam longint SMAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint SMIN = 64'sh8000_0000_0000_0000;

  typedef struct packed {
    bit            win;
    bit [DW-1:0]   pz;
    bit [DW-1:0]   px;
    bit [DW-1:0]   py;
    bit [DW-1:0]   ke;
  } momentum_t;

  class momentum_scoreboard;
    bit [63:0]  cal_regs[dhmc_pkg::NUM_REGS];
    momentum_t  awaited[$];
    int         errors;

    function longint fld(bit [63:0] r, int slot, int w);
      bit [63:0] s;
      s = r >> (slot * w);
      s = s << (64 - w);
      return longint'(s) >>> (64 - w);
    endfunction

    function longint sadd(longint a, longint b);
      longint s;
      s = a + b;
      if (a[63] == b[63] && s[63] != a[63]) return a[63] ? SMIN : SMAX;
      return s;
    endfunction

    // fixed-point product, truncated toward zero, magnitude clipped at 2^63-1
    function longint qmul(longint a, longint b, int frac);
      bit          neg;
      bit [63:0]   ma, mb, mag;
      bit [127:0]  p;
      neg = (a < 0) != (b < 0);
      ma = (a < 0) ? 64'(-a) : 64'(a);
      mb = (b < 0) ? 64'(-b) : 64'(b);
      p = {64'b0, ma} * {64'b0, mb};
      p = p >> frac;
      mag = (|p[127:63]) ? 64'(SMAX) : p[63:0];
      return neg ? -longint'(mag) : longint'(mag);
    endfunction

    function longint dm(longint a, longint b);
      return qmul(a, b, dhmc_pkg::DATA_FRAC);
    endfunction

    function longint cm(longint c, longint v);
      return qmul(c, v, dhmc_pkg::COEFF_FRAC);
    endfunction

    function longint coef(int lo_reg, int k);
      if (k < 4) return fld(cal_regs[lo_reg], k, CW);
      return fld(cal_regs[lo_reg + 1], k - 4, CW);
    endfunction

    function longint clip_data(longint v);
      longint hi, lo;
      hi = (64'sd1 <<< (DW - 1)) - 1;
      lo = -hi - 1;
      return v > hi ? hi : (v < lo ? lo : v);
    endfunction

    function longint transverse(longint u, longint t, longint t3, longint t5);
      longint u2, u3, u5, s;
      u2 = dm(u, u);
      u3 = dm(u2, u);
      u5 = dm(u3, u2);
      s = cm(coef(dhmc_pkg::REG_PR_LO, 0), u);
      s = sadd(s, cm(coef(dhmc_pkg::REG_PR_LO, 1), dm(u, t)));
      s = sadd(s, cm(coef(dhmc_pkg::REG_PR_LO, 2), dm(u3, t)));
      s = sadd(s, cm(coef(dhmc_pkg::REG_PR_LO, 3), dm(u5, t)));
      s = sadd(s, cm(coef(dhmc_pkg::REG_PR_LO, 4), t3));
      s = sadd(s, cm(coef(dhmc_pkg::REG_PR_LO, 5), t5));
      return s;
    endfunction

    function momentum_t calibrate(longint t, longint x, longint y);
      momentum_t r;
      longint lo, hi, t0, imass, cs, sn, scx, scy, x0, y0, ct, cx, cy;
      longint r2, t2, t3, t4, t5, pz, px, py, sum, ke;
      r = '0;
      lo = fld(cal_regs[dhmc_pkg::REG_WINDOW], 0, DW);
      hi = fld(cal_regs[dhmc_pkg::REG_WINDOW], 1, DW);
      if (!(lo <= t && t <= hi)) return r;
      t0 = fld(cal_regs[dhmc_pkg::REG_T0_IMASS], 0, DW);
      imass = longint'({32'b0, cal_regs[dhmc_pkg::REG_T0_IMASS][63:32]});
      cs  = fld(cal_regs[dhmc_pkg::REG_ROT_SCALE], 0, CW);
      sn  = fld(cal_regs[dhmc_pkg::REG_ROT_SCALE], 1, CW);
      scx = fld(cal_regs[dhmc_pkg::REG_ROT_SCALE], 2, CW);
      scy = fld(cal_regs[dhmc_pkg::REG_ROT_SCALE], 3, CW);
      x0 = fld(cal_regs[dhmc_pkg::REG_CENTER], 0, DW);
      y0 = fld(cal_regs[dhmc_pkg::REG_CENTER], 1, DW);
      ct = sadd(t, -t0);
      cx = cm(scx, sadd(sadd(cm(cs, x), -cm(sn, y)), -x0));
      cy = cm(scy, sadd(sadd(cm(sn, x), cm(cs, y)), -y0));
      r2 = sadd(dm(cx, cx), dm(cy, cy));
      t2 = dm(ct, ct);
      t3 = dm(t2, ct);
      t4 = dm(t3, ct);
      t5 = dm(t4, ct);
      pz = cm(coef(dhmc_pkg::REG_PZ_LO, 0), 64'sd1 <<< dhmc_pkg::DATA_FRAC);
      pz = sadd(pz, cm(coef(dhmc_pkg::REG_PZ_LO, 1), ct));
      pz = sadd(pz, cm(coef(dhmc_pkg::REG_PZ_LO, 2), t2));
      pz = sadd(pz, cm(coef(dhmc_pkg::REG_PZ_LO, 3), t3));
      pz = sadd(pz, cm(coef(dhmc_pkg::REG_PZ_LO, 4), t4));
      pz = sadd(pz, cm(coef(dhmc_pkg::REG_PZ_LO, 5), r2));
      pz = sadd(pz, cm(coef(dhmc_pkg::REG_PZ_LO, 6), dm(r2, r2)));
      pz = clip_data(pz);
      px = clip_data(transverse(cx, ct, t3, t5));
      py = clip_data(transverse(cy, ct, t3, t5));
      sum = sadd(sadd(dm(pz, pz), dm(px, px)), dm(py, py));
      ke = dm(sum / 2, imass);
      if (ke > longint'({32'b0, {DW{1'b1}}})) ke = longint'({32'b0, {DW{1'b1}}});
      if (ke < 0) ke = 0;
      r.win = 1'b1;
      r.pz = pz[DW-1:0];
      r.px = px[DW-1:0];
      r.py = py[DW-1:0];
      r.ke = ke[DW-1:0];
      return r;
    endfunction

    function void note_hit(bit [DW-1:0] t, bit [DW-1:0] x, bit [DW-1:0] y);
      awaited = {awaited, calibrate(longint'($signed(t)), longint'($signed(x)),
                                    longint'($signed(y)))};
    endfunction

    function void check_result(momentum_t got);
      momentum_t want;
      bit [DW-1:0] g[5], w[5];
      string nm[5];
      if (awaited.size() == 0) begin
        $display("%0t: unexpected result beat %p", $time, got);
        errors++;
        return;
      end
      want = awaited.pop_front();
      nm = '{"in_window", "momentum_z", "momentum_x", "momentum_y", "kinetic_energy"};
      g = '{DW'(got.win), got.pz, got.px, got.py, got.ke};
      w = '{DW'(want.win), want.pz, want.px, want.py, want.ke};
      for (int i = 0; i < 5; i++) begin
        if (g[i] !== w[i]) begin
          $display("%0t: %s expected %h actual %h", $time, nm[i], w[i], g[i]);
          errors++;
        end
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  logic signed [DW-1:0] in_hit_time = '0, in_hit_x = '0, in_hit_y = '0;
  logic out_valid;
  logic out_stall = 0;
  logic out_in_window;
  logic signed [DW-1:0] out_momentum_z, out_momentum_x, out_momentum_y;
  logic [DW-1:0] out_kinetic_energy;
  logic cfg_we = 0;
  logic [dhmc_pkg::REG_IDX_W-1:0] cfg_index = '0;
  logic [63:0] cfg_data = '0;

  momentum_scoreboard sb = new();
  bit quiet;  // no idling on either side while set
  bit [63:0] win_reg;

  detector_hit_momentum_calibration i_dut (.*);

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) sb.note_hit(in_hit_time, in_hit_x, in_hit_y);
    if (rst_n && out_valid && !out_stall)
      sb.check_result('{out_in_window, out_momentum_z, out_momentum_x, out_momentum_y,
                        out_kinetic_energy});
  end

  // result side back-pressure
  initial begin
    int n;
    forever begin
      n = quiet ? 0 : $urandom_range(0, 11);
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(rst_n && out_valid));
    end
  end

  task automatic send_hit(bit [DW-1:0] t, bit [DW-1:0] x, bit [DW-1:0] y);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_hit_time <= t;
    in_hit_x <= x;
    in_hit_y <= y;
    do @(posedge clk); while (in_stall);
  endtask

  // drain the pipeline fully before touching registers
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic load_regs(bit [63:0] vals[dhmc_pkg::NUM_REGS]);
    logic [dhmc_pkg::REG_IDX_W-1:0] idx[dhmc_pkg::NUM_REGS];
    idx = '{dhmc_pkg::REG_PZ_LO, dhmc_pkg::REG_PZ_HI, dhmc_pkg::REG_PR_LO,
            dhmc_pkg::REG_PR_HI, dhmc_pkg::REG_WINDOW, dhmc_pkg::REG_T0_IMASS,
            dhmc_pkg::REG_ROT_SCALE, dhmc_pkg::REG_CENTER};
    foreach (idx[i]) begin
      cfg_we <= 1'b1;
      cfg_index <= idx[i];
      cfg_data <= vals[i];
      sb.cal_regs[idx[i]] = vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  function automatic bit [63:0] pack_coeffs(int kind);
    bit [63:0] r;
    for (int i = 0; i < 4; i++) begin
      case (kind)
        0: r[i*16 +: 16] = 16'h7FFF;
        1: r[i*16 +: 16] = 16'h8000;
        2: r[i*16 +: 16] = 16'($urandom);
        default: r[i*16 +: 16] = 16'($urandom_range(0, 4095) - 2048);
      endcase
    end
    return r;
  endfunction

  function automatic bit [DW-1:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return DW'(int'($urandom_range(0, 1 << 20)) - (1 << 19));
      default: return DW'(int'($urandom_range(0, 1 << 19)) - (1 << 18));
    endcase
  endfunction

  function automatic bit [DW-1:0] rand_time();
    longint lo, hi, span;
    lo = longint'($signed(win_reg[31:0]));
    hi = longint'($signed(win_reg[63:32]));
    if (lo > hi || $urandom_range(0, 3) == 0) return $urandom;
    span = hi - lo + 1;
    return DW'(lo + longint'({$urandom, $urandom} % 64'(span)));
  endfunction

  initial begin
    bit [63:0] v[dhmc_pkg::NUM_REGS];
    bit [DW-1:0] ext[5];
    int kind;
    quiet = 1'b0;
    win_reg = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset values: window is [0, 0]
    send_hit('0, 32'h0001_0000, 32'hFFFF_0000);
    send_hit(32'h1, '0, '0);
    send_hit(32'hFFFF_FFFF, '0, '0);

    ext = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h0001_0000};
    for (int ph = 0; ph < 10; ph++) begin
      drain();
      kind = (ph < 3) ? ph : 3 - (ph % 2);
      v[dhmc_pkg::REG_PZ_LO] = pack_coeffs(kind);
      v[dhmc_pkg::REG_PZ_HI] = pack_coeffs(kind);
      v[dhmc_pkg::REG_PR_LO] = pack_coeffs(kind);
      v[dhmc_pkg::REG_PR_HI] = pack_coeffs(kind);
      case (ph)
        0, 1: v[dhmc_pkg::REG_WINDOW] = 64'h7FFF_FFFF_8000_0000;
        2: v[dhmc_pkg::REG_WINDOW] = 64'hFFF6_0000_000A_0000;  // lower above upper
        default: v[dhmc_pkg::REG_WINDOW] = {32'($urandom_range(0, 100 << 16)),
                                            32'(-int'($urandom_range(0, 100 << 16)))};
      endcase
      v[dhmc_pkg::REG_T0_IMASS] = (ph < 2)
          ? {32'hFFFF_FFFF, (ph == 0) ? 32'h7FFF_FFFF : 32'h8000_0000}
          : {32'($urandom_range(0, 1 << 17)),
             32'(int'($urandom_range(0, 1 << 18)) - (1 << 17))};
      v[dhmc_pkg::REG_ROT_SCALE] = (ph < 2) ? pack_coeffs(kind)
          : (ph % 3 == 0) ? pack_coeffs(2)
          : {16'($urandom_range(2048, 8192)), 16'($urandom_range(2048, 8192)),
             16'($urandom_range(0, 8191) - 4096), 16'h1000};
      v[dhmc_pkg::REG_CENTER] = (ph < 2) ? {2{(ph == 0) ? 32'h7FFF_FFFF : 32'h8000_0000}}
          : {32'(int'($urandom_range(0, 1 << 18)) - (1 << 17)),
             32'(int'($urandom_range(0, 1 << 18)) - (1 << 17))};
      load_regs(v);
      win_reg = v[dhmc_pkg::REG_WINDOW];
      quiet = (ph == 4);

      if (ph < 2) begin
        // field extremes through the full window
        for (int i = 0; i < 5; i++) send_hit(ext[i], ext[(i + 1) % 5], ext[(i + 3) % 5]);
      end else if (ph == 3) begin
        // window edges, just inside and just outside
        send_hit(win_reg[31:0], rand_coord(), rand_coord());
        send_hit(win_reg[63:32], rand_coord(), rand_coord());
        send_hit(win_reg[31:0] - 1, rand_coord(), rand_coord());
        send_hit(win_reg[63:32] + 1, rand_coord(), rand_coord());
      end
      for (int n = 0; n < 100; n++) send_hit(rand_time(), rand_coord(), rand_coord());
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (sb.errors == 0) begin
      $display("detector_hit_momentum_calibration: match");
    end else begin
      $display("detector_hit_momentum_calibration: mismatch");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("detector_hit_momentum_calibration: mismatch");
    $finish;
  end

endmodule
